// File: design/key_press_classifier_queue_core_defines.svh
// Assertion macros shared by the key press classifier checker.
`ifndef KEY_PRESS_CLASSIFIER_QUEUE_CORE_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key press classifier check failed");

// Next-cycle implication, checked outside reset.
`define KPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key press classifier check failed");

`endif

// File: design/kpc_pkg.sv
// Shared types and constants of the key press classifier.
package kpc_pkg;

  localparam int unsigned QueueDepth    = 16;
  localparam int unsigned DefaultFilter = 20;
  localparam int unsigned HoldToRepeat  = 50;
  localparam int unsigned NoKeyCode     = 0;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgFilterTicks = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLongTicks   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatTicks = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgShortCode   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLongCode    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgReleaseCode = 3'd5;

  typedef enum logic {
    OpTick = 1'b0,
    OpRead = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhDebounce = 3'd1,
    PhLongWait = 3'd2,
    PhRepeat   = 3'd3,
    PhRelease  = 3'd4
  } phase_e;

  typedef struct packed {
    logic func;
    logic key_down;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_code;
    logic       read_valid;
    logic       dropped;
    logic [4:0] queue_count;
  } out_item_t;

  // Decoded request handed from the front to the back.
  typedef struct packed {
    op_e  op;
    logic key_down;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  filter_ticks;
    logic [15:0] long_ticks;
    logic [7:0]  repeat_ticks;
    logic [7:0]  short_code;
    logic [7:0]  long_code;
    logic [7:0]  release_code;
  } cfg_t;

endpackage

// File: design/kpc_front.sv
// Front end: accepts requests, decodes them and buffers them in a two-entry queue.
module kpc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  kpc_pkg::in_item_t in_i,
  output logic              cmd_valid_o,
  output kpc_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);
  import kpc_pkg::*;

  cmd_t       entry_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;
  cmd_t       dec;

  always_comb begin
    dec.op       = in_i.func ? OpRead : OpTick;
    dec.key_down = in_i.key_down;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rp_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wp_d  = wr_en ? !wp_q : wp_q;
    rp_d  = rd_en ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wp_q] <= dec;
    end
  end

endmodule

// File: design/kpc_back.sv
// Back end: key phase machine, code queue and configuration registers.
module kpc_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [kpc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             cmd_valid_i,
  input  kpc_pkg::cmd_t                    cmd_i,
  output logic                             cmd_pop_o,
  input  logic                             res_full_i,
  output logic                             res_push_o,
  output kpc_pkg::out_item_t               res_o
);
  import kpc_pkg::*;

  cfg_t            cfg_q;
  phase_e          phase_q, phase_d;
  logic [7:0]      deb_q, deb_d, deb_inc, filt;
  logic [15:0]     hold_q, hold_d, hold_inc;
  logic [PtrW-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CntW-1:0] held_q, held_d;
  logic [7:0]      store_q [QueueDepth];
  logic            fire, do_tick, do_read, down;
  logic            deb_done, enq, q_full, q_write, q_read;
  logic [7:0]      enq_code;

  // Configuration must be written only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFilterTicks: cfg_q.filter_ticks <= cfg_data_i[7:0];
        CfgLongTicks:   cfg_q.long_ticks   <= cfg_data_i[15:0];
        CfgRepeatTicks: cfg_q.repeat_ticks <= cfg_data_i[7:0];
        CfgShortCode:   cfg_q.short_code   <= cfg_data_i[7:0];
        CfgLongCode:    cfg_q.long_code    <= cfg_data_i[7:0];
        CfgReleaseCode: cfg_q.release_code <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign fire      = cmd_valid_i && !res_full_i;
  assign cmd_pop_o = fire;
  assign do_tick   = fire && (cmd_i.op == OpTick);
  assign do_read   = fire && (cmd_i.op == OpRead);
  assign down      = cmd_i.key_down;

  assign filt     = (cfg_q.filter_ticks == 8'd0) ? 8'(DefaultFilter) : cfg_q.filter_ticks;
  assign deb_inc  = deb_q + 8'd1;
  assign hold_inc = hold_q + 16'd1;
  assign deb_done = (deb_inc >= filt);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (do_tick) begin
      unique case (phase_q)
        PhIdle: begin
          if (down) phase_d = PhDebounce;
        end
        PhDebounce: begin
          if (deb_done) begin
            if (!down) phase_d = PhIdle;
            else if (cfg_q.long_ticks == '0 && cfg_q.repeat_ticks == '0) phase_d = PhRelease;
            else phase_d = PhLongWait;
          end
        end
        PhLongWait: begin
          if (cfg_q.long_ticks != '0) begin
            if (!down) phase_d = PhRelease;
            else if (hold_inc >= cfg_q.long_ticks) begin
              phase_d = (cfg_q.repeat_ticks == '0) ? PhRelease : PhRepeat;
            end
          end else if (cfg_q.repeat_ticks != '0) begin
            if (!down) phase_d = PhRelease;
            else if (hold_inc >= 16'(HoldToRepeat)) phase_d = PhRepeat;
          end else begin
            phase_d = PhRelease;
          end
        end
        PhRepeat: begin
          if (!(cfg_q.repeat_ticks != '0 && down)) phase_d = PhRelease;
        end
        PhRelease: begin
          if (deb_done && !down) phase_d = PhIdle;
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  // Counters and the code that the phase machine wants to queue.
  always_comb begin
    deb_d    = deb_q;
    hold_d   = hold_q;
    enq      = 1'b0;
    enq_code = cfg_q.short_code;
    if (do_tick) begin
      unique case (phase_q)
        PhIdle: ;
        PhDebounce: begin
          deb_d = deb_done ? 8'd0 : deb_inc;
          if (deb_done && down && cfg_q.long_ticks == '0 && cfg_q.repeat_ticks == '0) begin
            enq = 1'b1;
          end
        end
        PhLongWait: begin
          if (cfg_q.long_ticks != '0) begin
            if (down) begin
              hold_d = hold_inc;
              if (hold_inc >= cfg_q.long_ticks) begin
                enq      = 1'b1;
                enq_code = cfg_q.long_code;
                hold_d   = '0;
              end
            end else begin
              enq    = 1'b1;
              hold_d = '0;
            end
          end else if (cfg_q.repeat_ticks != '0) begin
            if (down) begin
              hold_d = (hold_inc >= 16'(HoldToRepeat)) ? 16'd0 : hold_inc;
            end else begin
              enq    = 1'b1;
              hold_d = '0;
            end
          end else begin
            enq = 1'b1;
          end
        end
        PhRepeat: begin
          if (cfg_q.repeat_ticks != '0 && down) begin
            hold_d = hold_inc;
            if (hold_inc >= {8'd0, cfg_q.repeat_ticks}) begin
              enq    = 1'b1;
              hold_d = '0;
            end
          end else begin
            hold_d = '0;
          end
        end
        PhRelease: begin
          deb_d = deb_done ? 8'd0 : deb_inc;
          if (deb_done && !down && cfg_q.release_code != 8'(NoKeyCode)) begin
            enq      = 1'b1;
            enq_code = cfg_q.release_code;
          end
        end
        default: ;
      endcase
    end
  end

  assign q_full  = (held_q == CntW'(QueueDepth));
  assign q_write = enq && !q_full;
  assign q_read  = do_read && (held_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    held_d = held_q;
    if (q_write) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      held_d = held_q + CntW'(1);
    end
    if (q_read) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      held_d = held_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      deb_q   <= '0;
      hold_q  <= '0;
      rptr_q  <= '0;
      wptr_q  <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      deb_q   <= deb_d;
      hold_q  <= hold_d;
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_write) begin
      store_q[wptr_q] <= enq_code;
    end
  end

  assign res_push_o = fire;

  always_comb begin
    res_o.read_code   = q_read ? store_q[rptr_q] : 8'(NoKeyCode);
    res_o.read_valid  = q_read;
    res_o.dropped     = enq && q_full;
    res_o.queue_count = 5'(held_d);
  end

endmodule

// File: design/kpc_rq.sv
// Result queue: two-entry buffer between the back end and the result port.
module kpc_rq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_push_i,
  input  kpc_pkg::out_item_t res_i,
  output logic               res_full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output kpc_pkg::out_item_t out_o
);
  import kpc_pkg::*;

  out_item_t  entry_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign out_o      = entry_q[rp_q];
  assign wr_en      = res_push_i && !res_full_o;
  assign rd_en      = pop_i && !empty_o;

  always_comb begin
    wp_d  = wr_en ? !wp_q : wp_q;
    rp_d  = rd_en ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wp_q] <= res_i;
    end
  end

endmodule

// File: design/key_press_classifier_queue_core.sv
// Top level of the single-key press classifier with its code queue.
// Ticks carry the key level and drive a debounce, long-press and auto-repeat
// phase machine that queues key codes in a 16-entry ring; read requests pop the
// oldest code, or return the no-key code when the ring is empty. Every request
// yields exactly one result. The block sustains one request per clock cycle
// while neither queue is full; the phase update and the single ring access of a
// request are combinational in the back end. A request is registered in the front
// queue and its result in the result queue; both two-entry queues let either side
// stall independently. Configuration registers are written at any edge with
// cfg_we_i high and must only change while no request is outstanding.
module key_press_classifier_queue_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  kpc_pkg::in_item_t            in_i,
  output logic                         empty,
  input  logic                         pop,
  output kpc_pkg::out_item_t           out_o,
  input  logic                         cfg_we_i,
  input  logic [kpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kpc_pkg::CfgDataW-1:0] cfg_data_i
);
  import kpc_pkg::*;

  logic      cmd_valid, cmd_pop, res_full, res_push;
  cmd_t      cmd;
  out_item_t res;

  kpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  kpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  kpc_rq u_rq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_o)
  );

endmodule

// File: design/kpc_checker.sv
// Port-level checks for the key press classifier, bound to the top level.
`include "key_press_classifier_queue_core_defines.svh"

module kpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input kpc_pkg::out_item_t out_o
);
  import kpc_pkg::*;

  // A result comes either from a read or from a tick, never both.
  `KPC_ASSERT_NOW(a_read_or_drop, !empty, !(out_o.read_valid && out_o.dropped))

  // A result without a popped code carries the no-key code.
  `KPC_ASSERT_NOW(a_nokey_code, !empty && !out_o.read_valid, out_o.read_code == 8'(NoKeyCode))

  // A code is only dropped when the ring is full.
  `KPC_ASSERT_NOW(a_drop_full, !empty && out_o.dropped, out_o.queue_count == 5'(QueueDepth))

  // A waiting result holds until it is popped.
  `KPC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_o))

endmodule

bind key_press_classifier_queue_core kpc_checker u_kpc_checker (.*);
